[sv/fqd_pkg.sv]
// fqd_pkg: types, codes and per-byte parse functions of the FASTQ record deframer.
// Standalone package; used by fastq_record_deframer.sv.
`default_nettype none

package fqd_pkg;

  // Counter widths and result queue size
  localparam int LEN_W   = 32;
  localparam int REC_W   = 32;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [REC_W-1:0] rec_t;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HSTART = 6'b000001,
    PH_HBODY  = 6'b000010,
    PH_SSTART = 6'b000100,
    PH_SBODY  = 6'b001000,
    PH_SEP    = 6'b010000,
    PH_QUAL   = 6'b100000
  } phase_t;

  // Result kinds
  typedef enum logic [3:0] {
    KIND_HEADER    = 4'd0,
    KIND_SEQ       = 4'd1,
    KIND_QUAL      = 4'd2,
    KIND_REC_OK    = 4'd3,
    KIND_MISMATCH  = 4'd4,
    KIND_NO_AT     = 4'd5,
    KIND_NO_PLUS   = 4'd6,
    KIND_NO_RECORD = 4'd7,
    KIND_STREAM_END = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] rec;
    logic [31:0] seq_len;
    logic [31:0] qual_len;
    logic        last;
  } result_t;

  typedef struct packed {
    phase_t phase;
    len_t   seq;
    len_t   qual;
    rec_t   rec;
  } st_t;

  // Outcome of one byte through the line parser
  typedef struct packed {
    st_t     st;
    logic    halt;
    logic    emit;
    result_t res;
  } feed_t;

  function automatic len_t len_inc(len_t v);
    return (v == '1) ? v : v + len_t'(1);
  endfunction

  function automatic rec_t rec_inc(rec_t v);
    return (v == '1) ? v : v + rec_t'(1);
  endfunction

  function automatic result_t mk_res(kind_t kind, logic [7:0] data, rec_t rec,
                                     len_t seq_len, len_t qual_len);
    result_t r;
    r.kind     = kind;
    r.data     = data;
    r.rec      = rec;
    r.seq_len  = seq_len;
    r.qual_len = qual_len;
    r.last     = 1'b0;
    return r;
  endfunction

  // Record-done result from current lengths
  function automatic result_t rec_done_res(st_t st);
    kind_t k;
    k = (st.qual == st.seq) ? KIND_REC_OK : KIND_MISMATCH;
    return mk_res(k, 8'h00, st.rec, st.seq, st.qual);
  endfunction

  // End of a quality line (or of the '+' line)
  function automatic feed_t qline_end(feed_t f);
    feed_t o;
    o = f;
    if (f.st.qual >= f.st.seq) begin
      o.emit     = 1'b1;
      o.res      = rec_done_res(f.st);
      o.st.seq   = '0;
      o.st.qual  = '0;
      o.st.phase = PH_HSTART;
    end else begin
      o.st.phase = PH_QUAL;
    end
    return o;
  endfunction

  // One line byte through the parser
  function automatic feed_t feed(st_t st, logic [7:0] c);
    feed_t f;
    logic  nl;
    f.st   = st;
    f.halt = 1'b0;
    f.emit = 1'b0;
    f.res  = '0;
    nl     = (c == CH_LF);
    case (st.phase)
      PH_HBODY: begin
        if (nl) begin
          f.st.phase = PH_SSTART;
        end else begin
          f.emit = 1'b1;
          f.res  = mk_res(KIND_HEADER, c, st.rec, '0, '0);
        end
      end
      PH_SSTART, PH_SBODY: begin
        if (nl) begin
          f.st.phase = PH_SSTART;
        end else if (st.phase == PH_SSTART && c == CH_PLUS) begin
          f.st.phase = PH_SEP;
        end else begin
          f.st.seq   = len_inc(st.seq);
          f.emit     = 1'b1;
          f.res      = mk_res(KIND_SEQ, c, st.rec, '0, '0);
          f.st.phase = PH_SBODY;
        end
      end
      PH_SEP: begin
        if (nl) begin
          f = qline_end(f);
        end
      end
      PH_QUAL: begin
        if (nl) begin
          f = qline_end(f);
        end else begin
          f.st.qual = len_inc(st.qual);
          f.emit    = 1'b1;
          f.res     = mk_res(KIND_QUAL, c, st.rec, '0, '0);
        end
      end
      default: begin
        // header search
        f.st.phase = PH_HSTART;
        if (!nl) begin
          if (c == CH_AT) begin
            f.st.rec   = rec_inc(st.rec);
            f.st.seq   = '0;
            f.st.qual  = '0;
            f.emit     = 1'b1;
            f.res      = mk_res(KIND_HEADER, c, f.st.rec, '0, '0);
            f.st.phase = PH_HBODY;
          end else begin
            f.emit = 1'b1;
            f.res  = mk_res(KIND_NO_AT, 8'h00, rec_inc(st.rec), '0, '0);
            f.halt = 1'b1;
          end
        end
      end
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[sv/fqd_if.sv]
// fqd_in_if / fqd_out_if: valid/ready channels of the FASTQ record deframer.
// Standalone; no package dependency.
`default_nettype none

interface fqd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface fqd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_kind;
  logic [7:0]  out_byte;
  logic [31:0] out_record;
  logic [31:0] out_seq_length;
  logic [31:0] out_qual_length;
  logic        out_last;

  modport source (output valid, output out_kind, output out_byte, output out_record,
                  output out_seq_length, output out_qual_length, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_record,
                  input out_seq_length, input out_qual_length, input out_last,
                  output ready);
endinterface

`default_nettype wire

[sv/fastq_record_deframer.sv]
// fastq_record_deframer: FASTQ byte-stream parser, top level.
// Depends on fqd_pkg (types, parse functions) and fqd_if.sv (channels).
//
//  channel | dir | transfer payload                         | per transfer
//  in_ch   | in  | data_byte, end_of_input                  | one stream byte or end mark
//  out_ch  | out | out_kind, out_byte, out_record, lengths,  | one result, up to two per
//          |     | out_last                                 | input byte
//
// One input transfer per cycle while in_ch.ready is high. An accepted byte is
// held in the input register, then the parser updates state and pushes 0..2
// results into a 4-entry result queue, which drains one result per cycle while
// out_ch.ready is high. Sustained rate is one byte per cycle while out_ch.ready
// is high and bytes give at most one result each; else the input can stall.
// Reset (synchronous, rst_n low) clears parser state, input register and queue.
// Output stalls back up through the queue: the input register holds while
// fewer than two queue slots are free.
`default_nettype none

module fastq_record_deframer (
  input  wire logic clk,
  input  wire logic rst_n,
  fqd_in_if.sink    in_ch,
  fqd_out_if.source out_ch
);

  // Input register
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // Parser state
  fqd_pkg::phase_t phase_r, phase_nxt;
  fqd_pkg::len_t   seq_r, seq_nxt;
  fqd_pkg::len_t   qual_r, qual_nxt;
  fqd_pkg::rec_t   rec_r, rec_nxt;
  logic            pending_r, pending_nxt;
  logic            halted_r, halted_nxt;

  // Result queue
  fqd_pkg::result_t             q_r [fqd_pkg::Q_DEPTH];
  logic [fqd_pkg::Q_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [fqd_pkg::Q_CW-1:0]     cnt_r;

  logic             proc;
  logic             pop;
  logic [1:0]       n_push;
  fqd_pkg::result_t r0, r1, r_end, r_e;
  logic             e_pre;
  fqd_pkg::st_t     st_cur, st1;
  fqd_pkg::feed_t   fa, fb;
  logic             do_a, do_b, halt_a;

  // Parse only when two queue slots are free
  assign proc = s1_v_r && (cnt_r <= fqd_pkg::Q_CW'(fqd_pkg::Q_DEPTH - 2));
  assign pop  = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !s1_v_r || proc;

  assign st_cur.phase = phase_r;
  assign st_cur.seq   = seq_r;
  assign st_cur.qual  = qual_r;
  assign st_cur.rec   = rec_r;

  // Held CR goes through the parser first, then the current byte
  assign do_a   = pending_r && (s1_byte_r != fqd_pkg::CH_LF);
  assign fa     = fqd_pkg::feed(st_cur, fqd_pkg::CH_CR);
  assign halt_a = do_a && fa.halt;
  assign st1    = do_a ? fa.st : st_cur;
  assign fb     = fqd_pkg::feed(st1, s1_byte_r);
  assign do_b   = (s1_byte_r != fqd_pkg::CH_CR) && !halt_a;

  // End-of-input results
  assign r_end = fqd_pkg::mk_res(fqd_pkg::KIND_STREAM_END, 8'h00, rec_r, '0, '0);
  always_comb begin
    e_pre = 1'b0;
    r_e   = '0;
    if (!halted_r) begin
      case (phase_r)
        fqd_pkg::PH_HBODY, fqd_pkg::PH_SSTART, fqd_pkg::PH_SBODY: begin
          e_pre = 1'b1;
          r_e   = fqd_pkg::mk_res(fqd_pkg::KIND_NO_PLUS, 8'h00, rec_r, '0, '0);
        end
        fqd_pkg::PH_SEP, fqd_pkg::PH_QUAL: begin
          e_pre = 1'b1;
          r_e   = fqd_pkg::rec_done_res(st_cur);
        end
        default: begin
          if (rec_r == '0) begin
            e_pre = 1'b1;
            r_e   = fqd_pkg::mk_res(fqd_pkg::KIND_NO_RECORD, 8'h00, '0, '0, '0);
          end
        end
      endcase
    end
  end

  // Next state and results for the byte in the input register
  always_comb begin
    phase_nxt   = phase_r;
    seq_nxt     = seq_r;
    qual_nxt    = qual_r;
    rec_nxt     = rec_r;
    pending_nxt = pending_r;
    halted_nxt  = halted_r;
    n_push      = 2'd0;
    r0          = '0;
    r1          = '0;
    if (proc) begin
      if (s1_end_r) begin
        if (e_pre) begin
          r0     = r_e;
          r1     = r_end;
          n_push = 2'd2;
        end else begin
          r0     = r_end;
          n_push = 2'd1;
        end
        phase_nxt   = fqd_pkg::PH_HSTART;
        seq_nxt     = '0;
        qual_nxt    = '0;
        rec_nxt     = '0;
        pending_nxt = 1'b0;
        halted_nxt  = 1'b0;
      end else if (!halted_r) begin
        phase_nxt   = do_b ? fb.st.phase : st1.phase;
        seq_nxt     = do_b ? fb.st.seq : st1.seq;
        qual_nxt    = do_b ? fb.st.qual : st1.qual;
        rec_nxt     = do_b ? fb.st.rec : st1.rec;
        halted_nxt  = halt_a || (do_b && fb.halt);
        pending_nxt = (s1_byte_r == fqd_pkg::CH_CR) && !halt_a;
        if (do_a && fa.emit && do_b && fb.emit) begin
          r0     = fa.res;
          r1     = fb.res;
          n_push = 2'd2;
        end else if (do_a && fa.emit) begin
          r0     = fa.res;
          n_push = 2'd1;
        end else if (do_b && fb.emit) begin
          r0     = fb.res;
          n_push = 2'd1;
        end
      end
    end
    // mark last result of this byte
    if (n_push == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n_push == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      phase_r   <= fqd_pkg::PH_HSTART;
      seq_r     <= '0;
      qual_r    <= '0;
      rec_r     <= '0;
      pending_r <= 1'b0;
      halted_r  <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      phase_r   <= phase_nxt;
      seq_r     <= seq_nxt;
      qual_r    <= qual_nxt;
      rec_r     <= rec_nxt;
      pending_r <= pending_nxt;
      halted_r  <= halted_nxt;
      wr_ptr_r  <= wr_ptr_r + fqd_pkg::Q_AW'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + fqd_pkg::Q_AW'(1);
      end
      cnt_r <= cnt_r + fqd_pkg::Q_CW'(n_push) - fqd_pkg::Q_CW'(pop);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_end_r  <= in_ch.end_of_input;
    end
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= r0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + fqd_pkg::Q_AW'(1)] <= r1;
    end
  end

  // Result channel
  assign out_ch.valid           = (cnt_r != '0);
  assign out_ch.out_kind        = q_r[rd_ptr_r].kind;
  assign out_ch.out_byte        = q_r[rd_ptr_r].data;
  assign out_ch.out_record      = q_r[rd_ptr_r].rec;
  assign out_ch.out_seq_length  = q_r[rd_ptr_r].seq_len;
  assign out_ch.out_qual_length = q_r[rd_ptr_r].qual_len;
  assign out_ch.out_last        = q_r[rd_ptr_r].last;

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fqd_pkg::Q_CW'(fqd_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  a_cr_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> !halted_r)
    else $error("CR held while halted");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_end_r) |=>
      (phase_r == fqd_pkg::PH_HSTART && rec_r == '0 && !halted_r && !pending_r))
    else $error("state not cleared after end of input");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !(proc && s1_end_r)) |=> halted_r)
    else $error("halt released before end of input");

endmodule

`default_nettype wire
